// ===== sv/rsdp_pkg.sv =====
// rsdp_pkg: shared widths for the reboot schedule DP block.
// Used by the top level and the port checker; depends on nothing.
package rsdp_pkg;

	localparam int IN_W    = 16;  // data_amount and performance port width
	localparam int DAY_W   = 6;   // reboot_day port width
	localparam int TOTAL_W = 21;  // best_total port width

endpackage

// ===== sv/rsdp_day_ram.sv =====
// rsdp_day_ram: per-day value store, one write port and one registered read port.
// Standalone; no package use.
module rsdp_day_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/rsdp_table_ram.sv =====
// rsdp_table_ram: DP table store, one write port and two registered read ports.
// Standalone; no package use.
module rsdp_table_ram #(
	parameter int AW = 10,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [DW-1:0] rdata_a,
	output logic [DW-1:0] rdata_b
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// ===== sv/reboot_schedule_dp_core.sv =====
// reboot_schedule_dp_core: reboot schedule DP, load / table fill / traceback.
// Depends on rsdp_pkg, rsdp_day_ram and rsdp_table_ram.
//
// Usage: day words (data_amount, performance, last_day) come in on the
// day_valid/day_stall channel, one per cycle while loading. The word with
// last_day set, or the MAX_DAYS-th word, closes the schedule of n days; the
// block then raises day_stall while it fills the table and traces back.
// The fill walks the n(n+1)/2 live cells through one shared add/compare
// unit, each cell in read, min and add/max/write steps, and the traceback
// walks the days through the table's two read ports with a read and a
// compare step per day, so a schedule stays busy after its last word.
// Results leave on res_valid/res_stall: one word per reboot day in rising
// order (best_total 0, is_last 0), then one word with is_last 1 and the
// optimal total. A result register sits on the output; while the receiver
// stalls, the traceback waits before it loads the next result, and loading
// of the next schedule may start as soon as the final word is registered.
// Reset (arst_n low) clears the sequencer, the day count and the output
// valid; the stores hold no reset value and are always written before read.
module reboot_schedule_dp_core #(
	parameter int MAX_DAYS   = 32,
	parameter int VALUE_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        day_valid,
	output logic                        day_stall,
	input  logic [rsdp_pkg::IN_W-1:0]   data_amount,
	input  logic [rsdp_pkg::IN_W-1:0]   performance,
	input  logic                        last_day,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [rsdp_pkg::DAY_W-1:0]  reboot_day,
	output logic [rsdp_pkg::TOTAL_W-1:0] best_total,
	output logic                        is_last
);

	localparam int DW = (VALUE_BITS < rsdp_pkg::IN_W) ? VALUE_BITS : rsdp_pkg::IN_W;
	localparam int IW = (MAX_DAYS > 1) ? $clog2(MAX_DAYS) : 1;
	localparam int CW = $clog2(MAX_DAYS + 1);
	localparam int TW = DW + CW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FRD  = 3'd1;
	localparam logic [2:0] S_FMIN = 3'd2;
	localparam logic [2:0] S_FADD = 3'd3;
	localparam logic [2:0] S_TRD  = 3'd4;
	localparam logic [2:0] S_TCMP = 3'd5;
	localparam logic [2:0] S_TFIN = 3'd6;

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] n_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] j_q;
	logic [DW-1:0] x_q;
	logic [TW-1:0] t_q;
	logic [TW-1:0] first_q;

	logic                         res_valid_q;
	logic [rsdp_pkg::DAY_W-1:0]   reboot_day_q;
	logic [rsdp_pkg::TOTAL_W-1:0] best_total_q;
	logic                         is_last_q;

	logic          accept;
	logic          close_sched;
	logic          out_free;
	logic          res_load;
	logic [CW-1:0] cnt_inc;
	logic [CW-1:0] i_dec;
	logic [CW-1:0] j_dec;
	logic [CW-1:0] i_inc;
	logic [DW-1:0] d_rd;
	logic [DW-1:0] c_rd;
	logic [TW-1:0] tab_rd_a;
	logic [TW-1:0] tab_rd_b;
	logic [TW-1:0] keep_sum;
	logic [TW-1:0] cell_val;
	logic          tab_we;
	logic [2*IW-1:0] tab_waddr;
	logic [2*IW-1:0] tab_raddr_a;
	logic [2*IW-1:0] tab_raddr_b;
	logic          tr_eq;

	assign accept      = day_valid && !day_stall;
	assign day_stall   = (state_q != S_IDLE);
	assign cnt_inc     = cnt_q + CW'(1);
	assign close_sched = last_day || (cnt_inc == CW'(MAX_DAYS));
	assign out_free    = !res_valid_q || !res_stall;
	assign i_dec       = i_q - CW'(1);
	assign j_dec       = j_q - CW'(1);
	assign i_inc       = i_q + CW'(1);
	assign res_load    = ((state_q == S_TCMP) && tr_eq && out_free)
		|| ((state_q == S_TFIN) && out_free);

	rsdp_day_ram #(.DEPTH(MAX_DAYS), .AW(IW), .DW(DW)) u_data_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (cnt_q[IW-1:0]),
		.wdata (data_amount[DW-1:0]),
		.raddr (i_dec[IW-1:0]),
		.rdata (d_rd)
	);

	rsdp_day_ram #(.DEPTH(MAX_DAYS), .AW(IW), .DW(DW)) u_cap_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (cnt_q[IW-1:0]),
		.wdata (performance[DW-1:0]),
		.raddr (j_dec[IW-1:0]),
		.rdata (c_rd)
	);

	// fill reads cell (i+1, j+1); traceback reads (i, j) and (i+1, 1)
	always_comb begin
		if (state_q == S_TRD || state_q == S_TCMP) begin
			tab_raddr_a = {i_dec[IW-1:0], j_dec[IW-1:0]};
		end else begin
			tab_raddr_a = {i_q[IW-1:0], j_q[IW-1:0]};
		end
	end
	assign tab_raddr_b = {i_q[IW-1:0], IW'(0)};
	assign tab_waddr   = {i_dec[IW-1:0], j_dec[IW-1:0]};

	// shared unit: keep = next + min, take the larger of keep and reboot
	assign keep_sum = t_q + TW'(x_q);
	assign cell_val = (keep_sum > first_q) ? keep_sum : first_q;
	assign tab_we   = (state_q == S_FADD);
	assign tr_eq    = (tab_rd_a == tab_rd_b);

	rsdp_table_ram #(.AW(2 * IW), .DW(TW)) u_table_ram (
		.clk     (clk),
		.we      (tab_we),
		.waddr   (tab_waddr),
		.wdata   (cell_val),
		.raddr_a (tab_raddr_a),
		.raddr_b (tab_raddr_b),
		.rdata_a (tab_rd_a),
		.rdata_b (tab_rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			j_q         <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (close_sched) begin
							cnt_q   <= '0;
							n_q     <= cnt_inc;
							i_q     <= cnt_inc;
							j_q     <= cnt_inc;
							state_q <= S_FRD;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
				end
				S_FRD: begin
					state_q <= S_FMIN;
				end
				S_FMIN: begin
					state_q <= S_FADD;
				end
				S_FADD: begin
					// rows run from day n down to 1, columns from i down to 1
					if (j_q != CW'(1)) begin
						j_q     <= j_dec;
						state_q <= S_FRD;
					end else if (i_q != CW'(1)) begin
						i_q     <= i_dec;
						j_q     <= i_dec;
						state_q <= S_FRD;
					end else begin
						i_q     <= CW'(1);
						j_q     <= CW'(1);
						state_q <= (n_q == CW'(1)) ? S_TFIN : S_TRD;
					end
				end
				S_TRD: begin
					state_q <= S_TCMP;
				end
				S_TCMP: begin
					if (!tr_eq || out_free) begin
						if (tr_eq) begin
							j_q <= CW'(1);
						end else begin
							j_q <= j_q + CW'(1);
						end
						if (i_inc == n_q) begin
							state_q <= S_TFIN;
						end else begin
							i_q     <= i_inc;
							state_q <= S_TRD;
						end
					end
				end
				S_TFIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath and result payload
	always_ff @(posedge clk) begin
		if (state_q == S_FRD && i_q == n_q) begin
			first_q <= '0;
		end
		if (state_q == S_FMIN) begin
			x_q <= (d_rd < c_rd) ? d_rd : c_rd;
			t_q <= (i_q == n_q) ? '0 : tab_rd_a;
		end
		if (state_q == S_FADD && j_q == CW'(1)) begin
			first_q <= cell_val;
		end
		if (state_q == S_TCMP && tr_eq && out_free) begin
			reboot_day_q <= rsdp_pkg::DAY_W'(i_q);
			best_total_q <= '0;
			is_last_q    <= 1'b0;
		end
		if (state_q == S_TFIN && out_free) begin
			reboot_day_q <= '0;
			best_total_q <= rsdp_pkg::TOTAL_W'(first_q);
			is_last_q    <= 1'b1;
		end
	end

	assign res_valid  = res_valid_q;
	assign reboot_day = reboot_day_q;
	assign best_total = best_total_q;
	assign is_last    = is_last_q;

endmodule

// ===== sv/rsdp_checker.sv =====
// rsdp_checker: port-level checks for reboot_schedule_dp_core, bound to the top.
// Depends on rsdp_pkg.
module rsdp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         day_valid,
	input logic                         day_stall,
	input logic                         last_day,
	input logic                         res_valid,
	input logic                         res_stall,
	input logic [rsdp_pkg::DAY_W-1:0]   reboot_day,
	input logic [rsdp_pkg::TOTAL_W-1:0] best_total,
	input logic                         is_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(reboot_day)
			&& $stable(best_total) && $stable(is_last))
		else $error("result word changed while stalled");

	a_reboot_zero_total: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_last |-> best_total == '0 && reboot_day != '0)
		else $error("reboot word carries a total or day zero");

	a_final_day_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_last |-> reboot_day == '0)
		else $error("final word carries a reboot day");

	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		day_valid && !day_stall && last_day |=> day_stall)
		else $error("block took input right after the closing word");

endmodule

bind reboot_schedule_dp_core rsdp_checker u_rsdp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.day_valid  (day_valid),
	.day_stall  (day_stall),
	.last_day   (last_day),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.reboot_day (reboot_day),
	.best_total (best_total),
	.is_last    (is_last)
);
